FILE: rtl/bqtrem_pkg.sv
`timescale 1ns / 1ps
package bqtrem_pkg;

  // coefficient registers, Q2.16 signed
  localparam int COEF_W = 18;

  // digit-serial multiplier: multiplier operand padded to whole digits
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = 5;
  localparam int MUL_B_W    = DIGIT_W * MUL_DIGITS;

  // sine approximation, Q16 working values
  localparam int T_FRAC = 16;
  localparam int T_W    = 17;
  localparam int SINE_W = 16;
  localparam logic [T_W-1:0] T_ONE  = 17'h10000;
  localparam logic [T_W-1:0] SIN_C1 = 17'd102918;
  localparam logic [T_W-1:0] SIN_C3 = 17'd42120;
  localparam logic [T_W-1:0] SIN_C5 = 17'd4738;

  // configuration port
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_B0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd6;

  localparam logic [COEF_W-1:0] B0_RESET = 18'd65536;

  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

FILE: rtl/biquad_lowpass_stereo_tremolo_unit.sv
`timescale 1ns / 1ps
// Mono-in, stereo-out audio block: each input sample goes through a
// direct-form-I biquad (five Q2.16 coefficients, a1/a2 subtracted), the
// saturated filter output is kept as feedback history, and it is then scaled
// by sin(phase) for the left channel and sin(offset - phase) for the right,
// with the phase advancing by phase_step before every sample. All fifteen
// products (five taps, four per sine, one gain per channel) run one after
// another through a single 4-bit digit-serial multiplier, and the block takes
// no new sample until the last one's result has moved into the output
// register. A finished result waits in that output register while the next
// sample is taken in. The user must write registers over the APB-style port
// only while no sample is in flight; the block itself does not enforce this.
module biquad_lowpass_stereo_tremolo_unit #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEF_FRAC_BITS  = 16,
  parameter int PHASE_WIDTH     = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_left_sample,
  output logic signed [SAMPLE_WIDTH-1:0]    out_right_sample,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bqtrem_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [bqtrem_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [bqtrem_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                              cfg_pready
);

  bqtrem_pkg::coef_set_t  coefs;
  logic [PHASE_WIDTH-1:0] phase_step;
  logic [PHASE_WIDTH-1:0] phase_offset;

  bqtrem_cfg #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .coefs        (coefs),
    .phase_step   (phase_step),
    .phase_offset (phase_offset)
  );

  bqtrem_core #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .PHASE_WIDTH     (PHASE_WIDTH),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .coefs            (coefs),
    .phase_step       (phase_step),
    .phase_offset     (phase_offset)
  );

endmodule

FILE: rtl/bqtrem_mac.sv
`timescale 1ns / 1ps
module bqtrem_mac #(
  parameter int A_W = 18
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic signed [A_W-1:0]                         a,
  input  logic signed [bqtrem_pkg::COEF_W-1:0]          b,
  output logic                                          done,
  output logic signed [A_W+bqtrem_pkg::MUL_B_W-1:0]     prod
);

  localparam int P_W   = A_W + bqtrem_pkg::MUL_B_W;
  localparam int DW    = bqtrem_pkg::DIGIT_W;
  localparam int BW    = bqtrem_pkg::MUL_B_W;
  localparam int CNT_W = $clog2(bqtrem_pkg::MUL_DIGITS + 1);

  logic signed [A_W-1:0] a_r, a_nxt;
  logic [BW-1:0]         b_r, b_nxt;
  logic signed [P_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [DW-1:0]          digit;
  logic                   first;
  logic signed [DW:0]     dig_s;
  logic signed [A_W+DW:0] term;

  // msb digit first; only the top digit carries the sign
  assign digit = b_r[BW-1 -: DW];
  assign first = (cnt_r == CNT_W'(bqtrem_pkg::MUL_DIGITS));
  assign dig_s = {first & digit[DW-1], digit};
  assign term  = a_r * dig_s;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = BW'(b);
      p_nxt    = '0;
      cnt_nxt  = CNT_W'(bqtrem_pkg::MUL_DIGITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = (p_r <<< DW) + P_W'(term);
      b_nxt   = b_r << DW;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

FILE: rtl/bqtrem_cfg.sv
`timescale 1ns / 1ps
module bqtrem_cfg #(
  parameter int PHASE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bqtrem_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [bqtrem_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [bqtrem_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                              cfg_pready,
  output bqtrem_pkg::coef_set_t             coefs,
  output logic [PHASE_WIDTH-1:0]            phase_step,
  output logic [PHASE_WIDTH-1:0]            phase_offset
);

  localparam int DW = bqtrem_pkg::DATA_W;
  localparam int CW = bqtrem_pkg::COEF_W;

  bqtrem_pkg::coef_set_t        coef_r, coef_nxt;
  logic [PHASE_WIDTH-1:0]       step_r, step_nxt;
  logic [PHASE_WIDTH-1:0]       offset_r, offset_nxt;
  logic                         wr_en;
  logic [bqtrem_pkg::REG_IDX_W-1:0] idx;

  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx   = cfg_paddr[bqtrem_pkg::ADDR_W-1:2];

  always_comb begin
    coef_nxt   = coef_r;
    step_nxt   = step_r;
    offset_nxt = offset_r;
    if (wr_en) begin
      unique case (idx)
        bqtrem_pkg::REG_B0:     coef_nxt.b0 = cfg_pwdata[CW-1:0];
        bqtrem_pkg::REG_B1:     coef_nxt.b1 = cfg_pwdata[CW-1:0];
        bqtrem_pkg::REG_B2:     coef_nxt.b2 = cfg_pwdata[CW-1:0];
        bqtrem_pkg::REG_A1:     coef_nxt.a1 = cfg_pwdata[CW-1:0];
        bqtrem_pkg::REG_A2:     coef_nxt.a2 = cfg_pwdata[CW-1:0];
        bqtrem_pkg::REG_STEP:   step_nxt    = PHASE_WIDTH'(cfg_pwdata);
        bqtrem_pkg::REG_OFFSET: offset_nxt  = PHASE_WIDTH'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bqtrem_pkg::REG_B0:     cfg_prdata = DW'($signed(coef_r.b0));
      bqtrem_pkg::REG_B1:     cfg_prdata = DW'($signed(coef_r.b1));
      bqtrem_pkg::REG_B2:     cfg_prdata = DW'($signed(coef_r.b2));
      bqtrem_pkg::REG_A1:     cfg_prdata = DW'($signed(coef_r.a1));
      bqtrem_pkg::REG_A2:     cfg_prdata = DW'($signed(coef_r.a2));
      bqtrem_pkg::REG_STEP:   cfg_prdata = DW'(step_r);
      bqtrem_pkg::REG_OFFSET: cfg_prdata = DW'(offset_r);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= bqtrem_pkg::B0_RESET;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
      step_r    <= PHASE_WIDTH'(32'd527015);
      offset_r  <= PHASE_WIDTH'(32'd1766382618);
    end else begin
      coef_r    <= coef_nxt;
      step_r    <= step_nxt;
      offset_r  <= offset_nxt;
    end
  end

  assign cfg_pready   = 1'b1;
  assign coefs        = coef_r;
  assign phase_step   = step_r;
  assign phase_offset = offset_r;

endmodule

FILE: rtl/bqtrem_core.sv
`timescale 1ns / 1ps
module bqtrem_core #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEF_FRAC_BITS  = 16,
  parameter int PHASE_WIDTH     = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_sample,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_sample,
  input  bqtrem_pkg::coef_set_t          coefs,
  input  logic [PHASE_WIDTH-1:0]         phase_step,
  input  logic [PHASE_WIDTH-1:0]         phase_offset
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = bqtrem_pkg::COEF_W;
  localparam int TW     = bqtrem_pkg::T_W;
  localparam int AW     = (SW > TW + 1) ? SW : TW + 1;
  localparam int PW     = AW + bqtrem_pkg::MUL_B_W;
  localparam int SUMW   = PW + 3;
  localparam int P_BITS = SINE_TABLE_BITS - 2;
  localparam int T_SHIFT = bqtrem_pkg::T_FRAC - P_BITS;

  localparam logic signed [SUMW-1:0] SUM_HALF  = SUMW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [PW-1:0]   PROD_HALF = PW'(1) << 14;
  localparam logic signed [SW-1:0]   S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]   S_MIN = {1'b1, {(SW-1){1'b0}}};

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  // product schedule: five filter taps, then sine and gain per channel
  localparam logic [3:0] OP_B0    = 4'd0;
  localparam logic [3:0] OP_B1    = 4'd1;
  localparam logic [3:0] OP_B2    = 4'd2;
  localparam logic [3:0] OP_A1    = 4'd3;
  localparam logic [3:0] OP_A2    = 4'd4;
  localparam logic [3:0] OP_SQ_L  = 4'd5;
  localparam logic [3:0] OP_C5_L  = 4'd6;
  localparam logic [3:0] OP_IN_L  = 4'd7;
  localparam logic [3:0] OP_SIN_L = 4'd8;
  localparam logic [3:0] OP_TR_L  = 4'd9;
  localparam logic [3:0] OP_SQ_R  = 4'd10;
  localparam logic [3:0] OP_C5_R  = 4'd11;
  localparam logic [3:0] OP_IN_R  = 4'd12;
  localparam logic [3:0] OP_SIN_R = 4'd13;
  localparam logic [3:0] OP_TR_R  = 4'd14;

  logic [1:0]               state_r, state_nxt;
  logic [3:0]               op_r, op_nxt;
  logic signed [SW-1:0]     x_r, x_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [SW-1:0]     y1_r, y1_nxt, y2_r, y2_nxt, y_r, y_nxt;
  logic [PHASE_WIDTH-1:0]   phase_r, phase_nxt;
  logic signed [SUMW-1:0]   sum_r, sum_nxt;
  logic [TW-1:0]            t_r, t_nxt, t2_r, t2_nxt, inner_r, inner_nxt;
  logic [1:0]               quad_r, quad_nxt;
  logic signed [bqtrem_pkg::SINE_W-1:0] sine_r, sine_nxt;
  logic signed [SW-1:0]     left_r, left_nxt, right_r, right_nxt;
  logic signed [SW-1:0]     out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     mac_start, mac_done;
  logic signed [AW-1:0]     mac_a;
  logic signed [CW-1:0]     mac_b;
  logic signed [PW-1:0]     prod;

  logic [PHASE_WIDTH-1:0]     mir_phase, sel_phase;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [TW-1:0]              t_raw, t_cur;
  logic signed [SUMW-1:0]     rnd_sum, sh_sum;
  logic signed [SW-1:0]       y_new;
  logic signed [PW-1:0]       rnd_p, sh_p;
  logic signed [SW-1:0]       trem;
  logic [TW:0]                s_raw, s_rnd;
  logic [14:0]                s_mag;
  logic signed [bqtrem_pkg::SINE_W-1:0] sine_new;

  // sine argument: table index taken from the top bits of the phase
  assign mir_phase = phase_offset - phase_r;
  assign sel_phase = (op_r == OP_SQ_L) ? phase_r : mir_phase;
  assign idx       = sel_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
  assign quad      = idx[SINE_TABLE_BITS-1 -: 2];
  assign t_raw     = TW'(idx[P_BITS-1:0]) << T_SHIFT;
  assign t_cur     = quad[0] ? (bqtrem_pkg::T_ONE - t_raw) : t_raw;

  // filter output: round half up, floor shift, saturate
  assign rnd_sum = sum_r + SUM_HALF;
  assign sh_sum  = rnd_sum >>> COEF_FRAC_BITS;
  always_comb begin
    if ((&sh_sum[SUMW-1:SW-1]) || ~(|sh_sum[SUMW-1:SW-1])) begin
      y_new = sh_sum[SW-1:0];
    end else begin
      y_new = sh_sum[SUMW-1] ? S_MIN : S_MAX;
    end
  end

  // tremolo gain product back to sample format
  assign rnd_p = prod + PROD_HALF;
  assign sh_p  = rnd_p >>> 15;
  always_comb begin
    if ((&sh_p[PW-1:SW-1]) || ~(|sh_p[PW-1:SW-1])) begin
      trem = sh_p[SW-1:0];
    end else begin
      trem = sh_p[PW-1] ? S_MIN : S_MAX;
    end
  end

  // sine magnitude from Q16 to Q1.15, clamped, signed by quadrant
  assign s_raw    = prod[33:16];
  assign s_rnd    = (s_raw + (TW+1)'(1)) >> 1;
  assign s_mag    = (s_rnd > (TW+1)'(32767)) ? 15'h7fff : s_rnd[14:0];
  assign sine_new = quad_r[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  always_comb begin
    case (op_r) inside
      OP_B0: begin
        mac_a = AW'(x_r);
        mac_b = $signed(coefs.b0);
      end
      OP_B1: begin
        mac_a = AW'(x1_r);
        mac_b = $signed(coefs.b1);
      end
      OP_B2: begin
        mac_a = AW'(x2_r);
        mac_b = $signed(coefs.b2);
      end
      OP_A1: begin
        mac_a = AW'(y1_r);
        mac_b = $signed(coefs.a1);
      end
      OP_A2: begin
        mac_a = AW'(y2_r);
        mac_b = $signed(coefs.a2);
      end
      OP_SQ_L, OP_SQ_R: begin
        mac_a = $signed(AW'(t_cur));
        mac_b = $signed(CW'(t_cur));
      end
      OP_C5_L, OP_C5_R: begin
        mac_a = $signed(AW'(t2_r));
        mac_b = $signed(CW'(bqtrem_pkg::SIN_C5));
      end
      OP_IN_L, OP_IN_R: begin
        mac_a = $signed(AW'(t2_r));
        mac_b = $signed(CW'(inner_r));
      end
      OP_SIN_L, OP_SIN_R: begin
        mac_a = $signed(AW'(t_r));
        mac_b = $signed(CW'(inner_r));
      end
      OP_TR_L, OP_TR_R: begin
        mac_a = AW'(y_r);
        mac_b = CW'(sine_r);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  bqtrem_mac #(
    .A_W (AW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .done  (mac_done),
    .prod  (prod)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    y_nxt         = y_r;
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    inner_nxt     = inner_r;
    quad_nxt      = quad_r;
    sine_nxt      = sine_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r;
    mac_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          phase_nxt = phase_r + phase_step;
          op_nxt    = OP_B0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mac_start = 1'b1;
        if (op_r == OP_SQ_L) begin
          // filter sum is complete here: latch y and shift the history
          y_nxt  = y_new;
          x2_nxt = x1_r;
          x1_nxt = x_r;
          y2_nxt = y1_r;
          y1_nxt = y_new;
        end
        if (op_r == OP_SQ_L || op_r == OP_SQ_R) begin
          t_nxt    = t_cur;
          quad_nxt = quad;
        end
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          case (op_r) inside
            OP_B0:              sum_nxt   = SUMW'(prod);
            OP_B1, OP_B2:       sum_nxt   = sum_r + SUMW'(prod);
            OP_A1, OP_A2:       sum_nxt   = sum_r - SUMW'(prod);
            OP_SQ_L, OP_SQ_R:   t2_nxt    = prod[32:16];
            OP_C5_L, OP_C5_R:   inner_nxt = bqtrem_pkg::SIN_C3 - prod[32:16];
            OP_IN_L, OP_IN_R:   inner_nxt = bqtrem_pkg::SIN_C1 - prod[32:16];
            OP_SIN_L, OP_SIN_R: sine_nxt  = sine_new;
            OP_TR_L:            left_nxt  = trem;
            OP_TR_R:            right_nxt = trem;
            default: ;
          endcase
          if (op_r == OP_TR_R) begin
            state_nxt = ST_OUT;
          end else begin
            op_nxt    = op_r + 4'd1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_left_nxt  = left_r;
          out_right_nxt = right_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_B0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    sum_r       <= sum_nxt;
    t_r         <= t_nxt;
    t2_r        <= t2_nxt;
    inner_r     <= inner_nxt;
    quad_r      <= quad_nxt;
    sine_r      <= sine_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

endmodule

FILE: bench/biquad_lowpass_stereo_tremolo_unit_tb.sv
`timescale 1ns / 1ps
module biquad_lowpass_stereo_tremolo_unit_tb;

  localparam int SW = 16;
  localparam int PW = 32;
  localparam int COEF_FRAC_W = 16;
  localparam logic [bqtrem_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } stereo_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] out_left_sample;
  logic signed [SW-1:0] out_right_sample;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [bqtrem_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [bqtrem_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [bqtrem_pkg::DATA_W-1:0] cfg_prdata;
  logic                 cfg_pready;

  biquad_lowpass_stereo_tremolo_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #10 clk = ~clk;

  // filter and tremolo state as seen from outside
  longint      ff0 = 65536, ff1 = 0, ff2 = 0, fb1 = 0, fb2 = 0;
  logic [PW-1:0] lfo_step = 32'd527015;
  logic [PW-1:0] mirror_offset = 32'd1766382618;
  longint      x_d1 = 0, x_d2 = 0, y_d1 = 0, y_d2 = 0;
  logic [PW-1:0] lfo_phase = '0;

  logic [SW-1:0] sample_queue[$];
  stereo_t       expected_stereo[$];

  int  fail_count = 0;
  int  out_count = 0;
  int  src_gap = 0;
  int  snk_gap = 0;
  int  hold_left = 0;
  bit  hold_seen = 1'b0;
  bit  hold_req = 1'b0;
  bit  src_idle_en = 1'b1;
  bit  snk_idle_en = 1'b1;

  function automatic longint round_shr(longint a, int sh);
    return (a + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // polynomial sine on the top bits of the phase, q1.15
  function automatic longint lfo_sine(logic [PW-1:0] ph);
    logic [9:0]      idx;
    logic [1:0]      quad;
    longint unsigned t, t2, inner, s;
    idx   = ph[PW-1 -: 10];
    quad  = idx[9:8];
    t     = longint'(idx[7:0]) << 8;
    if (quad[0]) t = bqtrem_pkg::T_ONE - t;
    t2    = (t * t) >> 16;
    inner = bqtrem_pkg::SIN_C3 - ((t2 * bqtrem_pkg::SIN_C5) >> 16);
    inner = bqtrem_pkg::SIN_C1 - ((t2 * inner) >> 16);
    s     = (t * inner) >> 16;
    s     = (s + 1) >> 1;
    if (s > 32767) s = 32767;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic stereo_t filter_and_modulate(logic signed [SW-1:0] smp);
    longint        x, acc, y;
    logic [PW-1:0] mirrored;
    stereo_t       r;
    x         = longint'(smp);
    lfo_phase = lfo_phase + lfo_step;
    acc       = ff0 * x + ff1 * x_d1 + ff2 * x_d2 - fb1 * y_d1 - fb2 * y_d2;
    y         = clamp_sample(round_shr(acc, COEF_FRAC_W));
    x_d2      = x_d1;
    x_d1      = x;
    y_d2      = y_d1;
    y_d1      = y;
    mirrored  = mirror_offset - lfo_phase;
    r.left    = SW'(clamp_sample(round_shr(y * lfo_sine(lfo_phase), 15)));
    r.right   = SW'(clamp_sample(round_shr(y * lfo_sine(mirrored), 15)));
    return r;
  endfunction

  function automatic void apply_reg(logic [bqtrem_pkg::REG_IDX_W-1:0] idx,
                                    logic [bqtrem_pkg::DATA_W-1:0] data);
    case (idx)
      bqtrem_pkg::REG_B0:     ff0 = longint'($signed(data[bqtrem_pkg::COEF_W-1:0]));
      bqtrem_pkg::REG_B1:     ff1 = longint'($signed(data[bqtrem_pkg::COEF_W-1:0]));
      bqtrem_pkg::REG_B2:     ff2 = longint'($signed(data[bqtrem_pkg::COEF_W-1:0]));
      bqtrem_pkg::REG_A1:     fb1 = longint'($signed(data[bqtrem_pkg::COEF_W-1:0]));
      bqtrem_pkg::REG_A2:     fb2 = longint'($signed(data[bqtrem_pkg::COEF_W-1:0]));
      bqtrem_pkg::REG_STEP:   lfo_step = data;
      bqtrem_pkg::REG_OFFSET: mirror_offset = data;
      default: ;
    endcase
  endfunction

  task automatic write_reg(logic [bqtrem_pkg::REG_IDX_W-1:0] idx,
                           logic [bqtrem_pkg::DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic program_all(longint b0, longint b1, longint b2, longint a1, longint a2,
                             logic [PW-1:0] step, logic [PW-1:0] offset);
    write_reg(bqtrem_pkg::REG_B0, bqtrem_pkg::DATA_W'(b0));
    write_reg(bqtrem_pkg::REG_B1, bqtrem_pkg::DATA_W'(b1));
    write_reg(bqtrem_pkg::REG_B2, bqtrem_pkg::DATA_W'(b2));
    write_reg(bqtrem_pkg::REG_A1, bqtrem_pkg::DATA_W'(a1));
    write_reg(bqtrem_pkg::REG_A2, bqtrem_pkg::DATA_W'(a2));
    write_reg(bqtrem_pkg::REG_STEP, step);
    write_reg(bqtrem_pkg::REG_OFFSET, offset);
  endtask

  // stable second-order section, or raw register noise when raw is set
  task automatic program_random(bit raw);
    longint a1, a2, lim;
    if (raw) begin
      program_all(longint'($urandom()), longint'($urandom()), longint'($urandom()),
                  longint'($urandom()), longint'($urandom()), $urandom(), $urandom());
    end else begin
      a2  = longint'($urandom_range(0, 120000)) - 60000;
      lim = 65536 + a2 - 1024;
      a1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
      program_all(longint'($urandom_range(0, 24000)) - 12000,
                  longint'($urandom_range(0, 48000)) - 24000,
                  longint'($urandom_range(0, 24000)) - 12000,
                  a1, a2, $urandom_range(0, 32'h0020_0000), $urandom());
    end
    if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2:    v = SW'($urandom_range(0, 2047) - 1024);
      default: v = SW'($urandom_range(0, 16'hFFFF));
    endcase
    return v;
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) sample_queue.push_back(pick_sample());
  endtask

  // checked away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid || expected_stereo.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // input side: one nonblocking update of valid per edge
  always @(posedge clk) begin : drive_samples
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_stereo.push_back(filter_and_modulate(in_sample));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_sample <= sample_queue.pop_front();
          in_valid  <= 1'b1;
          if (src_idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_outputs
    stereo_t want;
    if (rst_n && out_valid && out_ready) begin
      out_count++;
      if (expected_stereo.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected transfer: left %0d right %0d", out_left_sample,
                   out_right_sample);
        fail_count++;
      end else begin
        want = expected_stereo.pop_front();
        if (out_left_sample !== want.left || out_right_sample !== want.right) begin
          if (fail_count < 10)
            $display("mismatch at output %0d: left exp %0d got %0d, right exp %0d got %0d",
                     out_count, want.left, out_left_sample, want.right, out_right_sample);
          fail_count++;
        end
      end
    end
  end

  initial begin : run_phases
    int mark;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients pass the input straight through
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h5A5A);
    wait_idle();

    // coefficient extremes drive the filter into saturation, quarter-turn steps
    program_all(131071, -131072, 131071, -131072, 131071, 32'h4000_0000, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h8000);
    wait_idle();

    // all coefficients at the negative limit, phase wraps every sample
    program_all(-131072, -131072, -131072, -131072, -131072, 32'hFFFF_FFFF, 32'h0);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h8000);
    wait_idle();

    program_random(1'b0);
    queue_random(120);
    wait_idle();

    // long receiver hold while the sender keeps offering
    program_random(1'b1);
    queue_random(120);
    mark = out_count;
    while (out_count < mark + 3) @(posedge clk);
    hold_req <= ~hold_req;
    wait_idle();

    program_random(1'b0);
    queue_random(120);
    wait_idle();

    program_random(1'b1);
    queue_random(120);
    wait_idle();

    src_idle_en <= 1'b0;
    snk_idle_en <= 1'b0;
    program_random(1'b0);
    queue_random(120);
    wait_idle();

    program_random(1'b1);
    queue_random(110);
    wait_idle();

    repeat (150) @(posedge clk);
    if (expected_stereo.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
